FILE: hw/rtl/eoct_pkg.sv
// Package for the endpoint operation counter table.
// Holds the word types, command codes, table entry layout and the control
// and status bundles shared by the controller and the datapath. No dependencies.
package eoct_pkg;

	// Default table geometry.
	localparam int unsigned EOCT_BUCKETS = 256;
	localparam int unsigned EOCT_WAYS    = 4;

	// Multiplier of the bucket hash.
	localparam logic [31:0] HASH_MULT = 32'h7b34_8943;

	// Command codes carried in the request word. Other codes act as a query.
	localparam logic [2:0] CMD_QUERY  = 3'd0;
	localparam logic [2:0] CMD_RD_INC = 3'd1;
	localparam logic [2:0] CMD_RD_DEC = 3'd2;
	localparam logic [2:0] CMD_WR_INC = 3'd3;
	localparam logic [2:0] CMD_WR_DEC = 3'd4;

	// Request word.
	typedef struct packed {
		logic [2:0]  cmd;
		logic [31:0] endpoint_addr;
		logic [15:0] endpoint_port;
	} eoct_req_t;

	// Response word.
	typedef struct packed {
		logic [31:0] read_count;
		logic [31:0] write_count;
		logic [31:0] total_count;
		logic        key_found;
		logic        table_full;
	} eoct_rsp_t;

	// One way of a bucket row.
	typedef struct packed {
		logic        valid;
		logic [47:0] key;
		logic [31:0] rd_cnt;
		logic [31:0] wr_cnt;
	} eoct_entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic capture;
		logic hash_add;
		logic mod_start;
		logic mod_step;
		logic row_read;
		logic match;
		logic update;
		logic clr_write;
		logic rsp_load;
	} eoct_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic mod_last;
		logic clr_last;
		logic rsp_free;
	} eoct_sts_t;

endpackage

FILE: hw/rtl/eoct_ctrl.sv
// Controller of the endpoint operation counter table.
// One-hot state machine that sequences the clearing pass and each item's
// hash, row read, match, update and response. Depends on eoct_pkg.
module eoct_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output eoct_pkg::eoct_cmd_t cmd,
	input  eoct_pkg::eoct_sts_t sts
);
	import eoct_pkg::*;

	typedef enum logic [7:0] {
		S_CLEAR = 8'b0000_0001,
		S_IDLE  = 8'b0000_0010,
		S_HASH  = 8'b0000_0100,
		S_MOD   = 8'b0000_1000,
		S_READ  = 8'b0001_0000,
		S_MATCH = 8'b0010_0000,
		S_UPD   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} eoct_state_t;

	eoct_state_t state_q;
	eoct_state_t state_nxt;

	// Next state and command decode.
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		req_stall = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_write = 1'b1;
				if (sts.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_HASH;
				end
			end
			S_HASH: begin
				cmd.hash_add  = 1'b1;
				cmd.mod_start = 1'b1;
				state_nxt     = S_MOD;
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) begin
					state_nxt = S_READ;
				end
			end
			S_READ: begin
				cmd.row_read = 1'b1;
				state_nxt    = S_MATCH;
			end
			S_MATCH: begin
				cmd.match = 1'b1;
				state_nxt = S_UPD;
			end
			S_UPD: begin
				cmd.update = 1'b1;
				state_nxt  = S_OUT;
			end
			S_OUT: begin
				if (sts.rsp_free) begin
					cmd.rsp_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

FILE: hw/rtl/eoct_dpath.sv
// Datapath of the endpoint operation counter table.
// Holds the hash unit, the bucket remainder unit, the bucket memory, the
// match and update logic and the response register. Depends on eoct_pkg.
module eoct_dpath #(
	parameter int unsigned BUCKETS = eoct_pkg::EOCT_BUCKETS,
	parameter int unsigned WAYS    = eoct_pkg::EOCT_WAYS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  eoct_pkg::eoct_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output eoct_pkg::eoct_rsp_t rsp,
	input  eoct_pkg::eoct_cmd_t cmd,
	output eoct_pkg::eoct_sts_t sts
);
	import eoct_pkg::*;

	localparam int unsigned BIDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam bit          POW2   = ((BUCKETS & (BUCKETS - 1)) == 0);

	eoct_req_t               req_q;
	logic [31:0]             prod_q;
	logic [31:0]             h_q;
	logic [BIDX_W-1:0]       bucket;
	logic                    mod_last;
	logic [BIDX_W-1:0]       clr_q;
	eoct_entry_t [WAYS-1:0]  mem_q [BUCKETS];
	eoct_entry_t [WAYS-1:0]  row_q;
	eoct_entry_t [WAYS-1:0]  row_new;
	logic [WAYS-1:0]         match_vec;
	logic [WAYS-1:0]         free_vec;
	logic [WAYS-1:0]         hit_oh_q;
	logic [WAYS-1:0]         free_oh_q;
	logic                    found_q;
	logic                    free_any_q;
	logic [47:0]             key;
	eoct_entry_t             sel;
	logic                    is_inc;
	logic [31:0]             upd_rd;
	logic [31:0]             upd_wr;
	logic [31:0]             ins_rd;
	logic [31:0]             ins_wr;
	logic [31:0]             res_rd;
	logic [31:0]             res_wr;
	logic                    res_full;
	logic [31:0]             rd_q;
	logic [31:0]             wr_q;
	logic                    found_res_q;
	logic                    full_q;
	logic                    rsp_valid_q;
	eoct_rsp_t               rsp_q;

	// Item capture and hash: the product is registered before the port is added.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q  <= req;
			prod_q <= 32'(req.endpoint_addr * HASH_MULT);
		end
		if (cmd.hash_add) begin
			h_q <= prod_q + {16'b0, req_q.endpoint_port};
		end
	end

	// Bucket index: a mask for a power-of-two bucket count. Otherwise a
	// multiply by the reciprocal gives a quotient at most one short, the
	// product is subtracted from the hash and one compare and subtract
	// corrects the remainder, one step per cycle.
	if (POW2) begin : g_mask
		assign bucket   = h_q[BIDX_W-1:0];
		assign mod_last = 1'b1;
	end else begin : g_rem
		localparam logic [31:0] RECIP = 32'((64'd1 << 32) / 64'(BUCKETS));

		logic [63:0]       prod_full;
		logic [31:0]       quot_q;
		logic [31:0]       part_q;
		logic [BIDX_W-1:0] rem_q;
		logic [1:0]        step_q;

		assign prod_full = 64'(h_q) * 64'(RECIP);
		assign bucket    = rem_q;
		assign mod_last  = (step_q == 2'd2);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				step_q <= 2'd0;
			end else if (cmd.mod_start) begin
				step_q <= 2'd0;
			end else if (cmd.mod_step) begin
				step_q <= step_q + 2'd1;
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.mod_step && step_q == 2'd0) begin
				quot_q <= prod_full[63:32];
			end
			if (cmd.mod_step && step_q == 2'd1) begin
				part_q <= h_q - 32'(quot_q * BUCKETS);
			end
			if (cmd.mod_step && step_q == 2'd2) begin
				if (part_q >= 32'(BUCKETS)) begin
					rem_q <= BIDX_W'(part_q - 32'(BUCKETS));
				end else begin
					rem_q <= BIDX_W'(part_q);
				end
			end
		end
	end

	// Clearing pass counter, one bucket row per cycle after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_write) begin
			clr_q <= clr_q + BIDX_W'(1);
		end
	end

	// Bucket memory: one row of all ways per bucket, registered read.
	always_ff @(posedge clk) begin
		if (cmd.clr_write) begin
			mem_q[clr_q] <= '0;
		end else if (cmd.update) begin
			mem_q[bucket] <= row_new;
		end
		if (cmd.row_read) begin
			row_q <= mem_q[bucket];
		end
	end

	// Way compare; the lowest matching and the lowest free way win.
	assign key = {req_q.endpoint_addr, req_q.endpoint_port};
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			match_vec[w] = row_q[w].valid && (row_q[w].key == key);
			free_vec[w]  = !row_q[w].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.match) begin
			hit_oh_q   <= match_vec & (~match_vec + WAYS'(1));
			free_oh_q  <= free_vec & (~free_vec + WAYS'(1));
			found_q    <= |match_vec;
			free_any_q <= |free_vec;
		end
	end

	// Counter update of the hit way, or the new entry for an insert.
	assign is_inc = (req_q.cmd == CMD_RD_INC) || (req_q.cmd == CMD_WR_INC);
	assign ins_rd = (req_q.cmd == CMD_RD_INC) ? 32'd1 : 32'd0;
	assign ins_wr = (req_q.cmd == CMD_WR_INC) ? 32'd1 : 32'd0;

	always_comb begin
		sel = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (hit_oh_q[w]) begin
				sel = row_q[w];
			end
		end
		upd_rd = sel.rd_cnt;
		upd_wr = sel.wr_cnt;
		unique case (req_q.cmd)
			CMD_RD_INC: upd_rd = sel.rd_cnt + 32'd1;
			CMD_RD_DEC: upd_rd = sel.rd_cnt - 32'd1;
			CMD_WR_INC: upd_wr = sel.wr_cnt + 32'd1;
			CMD_WR_DEC: upd_wr = sel.wr_cnt - 32'd1;
			default: begin
			end
		endcase
	end

	always_comb begin
		row_new  = row_q;
		res_rd   = 32'd0;
		res_wr   = 32'd0;
		res_full = 1'b0;
		if (found_q) begin
			res_rd = upd_rd;
			res_wr = upd_wr;
			for (int w = 0; w < WAYS; w++) begin
				if (hit_oh_q[w]) begin
					row_new[w].rd_cnt = upd_rd;
					row_new[w].wr_cnt = upd_wr;
				end
			end
		end else if (is_inc) begin
			if (free_any_q) begin
				res_rd = ins_rd;
				res_wr = ins_wr;
				for (int w = 0; w < WAYS; w++) begin
					if (free_oh_q[w]) begin
						row_new[w] = '{valid: 1'b1, key: key, rd_cnt: ins_rd, wr_cnt: ins_wr};
					end
				end
			end else begin
				res_full = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			rd_q        <= res_rd;
			wr_q        <= res_wr;
			found_res_q <= found_q;
			full_q      <= res_full;
		end
	end

	// Response register; the total is formed as the word is loaded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rsp_load) begin
			rsp_q.read_count  <= rd_q;
			rsp_q.write_count <= wr_q;
			rsp_q.total_count <= rd_q + wr_q;
			rsp_q.key_found   <= found_res_q;
			rsp_q.table_full  <= full_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign rsp          = rsp_q;
	assign sts.mod_last = mod_last;
	assign sts.clr_last = (clr_q == BIDX_W'(BUCKETS - 1));
	assign sts.rsp_free = !rsp_valid_q || !rsp_stall;

endmodule

FILE: hw/rtl/endpoint_op_counter_table_core.sv
// Top level of the endpoint operation counter table.
// Joins the controller and the datapath. Depends on eoct_pkg, eoct_ctrl
// and eoct_dpath.
//
// Usage: a request word (cmd, endpoint_addr, endpoint_port) is taken on the
// req channel when req_valid is high and req_stall is low. Each request gives
// exactly one response word on the rsp channel: the key's read and write
// counts after the command, their 32-bit total, whether the key was present
// and whether an insert was dropped for want of a free way.
// Items are handled one at a time. With a power-of-two bucket count the
// bucket index is a mask of the hash; otherwise the bucket remainder is
// formed by a reciprocal multiply, a subtraction and one correcting step.
// The pace is set by the single-ported bucket row memory (read, match,
// write back) and the hash remainder unit.
// After reset the block clears the valid bits one bucket row per cycle,
// with req_stall held high. A stalled response stays in the output
// register; the next request is still taken and waits, finished, until
// the register is free.
module endpoint_op_counter_table_core #(
	parameter int unsigned BUCKETS = eoct_pkg::EOCT_BUCKETS,
	parameter int unsigned WAYS    = eoct_pkg::EOCT_WAYS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  eoct_pkg::eoct_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output eoct_pkg::eoct_rsp_t rsp
);
	import eoct_pkg::*;

	eoct_cmd_t cmd;
	eoct_sts_t sts;

	// Sequencer.
	eoct_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Hash, table memory and response path.
	eoct_dpath #(
		.BUCKETS (BUCKETS),
		.WAYS    (WAYS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

FILE: hw/rtl/eoct_checker.sv
// Port checker for the endpoint operation counter table.
// Watches the top level's channels only and is bound to the top level at the
// end of this file. Depends on eoct_pkg and endpoint_op_counter_table_core.
module eoct_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input eoct_pkg::eoct_req_t req,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input eoct_pkg::eoct_rsp_t rsp
);
	import eoct_pkg::*;

	// A request held off by the block does not change.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("request word changed while stalled");

	// A response held by the receiver does not change.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// The total is the wrapped sum of the two counters.
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.total_count == 32'(rsp.read_count + rsp.write_count))
		else $error("total count is not read plus write");

	// A dropped insert reports an absent key with zero counts.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.table_full |->
		!rsp.key_found && rsp.read_count == 32'd0 && rsp.write_count == 32'd0)
		else $error("full report with key or counts");

	// One request at a time: the channel stalls right after a word is taken.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while one is in flight");

endmodule

bind endpoint_op_counter_table_core eoct_checker u_eoct_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
